[rtl/core/arff_pkg.sv]
`default_nettype none

package arff_pkg;

	// line store depth and the widths that follow from it
	localparam int MAX_LINE_WIDTH = 1024;
	localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
	localparam int LW_W           = 11;
	localparam int CNT_W          = $clog2(MAX_LINE_WIDTH + 1);
	localparam int CMP_W          = (LW_W > CNT_W) ? LW_W : CNT_W;

	// field and register widths
	localparam int NOISE_W = 16;
	localparam int VAL_W   = 20;
	localparam int COEF_W  = 16;
	localparam int GAIN_W  = 15;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	// stream bus widths
	localparam int S_TDATA_W = ((NOISE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((VAL_W + 7) / 8) * 8;

	// arithmetic: Q.27 accumulation, rounded back to Q.12
	localparam int PN_W     = GAIN_W + 1 + NOISE_W;
	localparam int PROD_W   = COEF_W + VAL_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int RND_SH   = 15;
	localparam int RND_HALF = 1 << (RND_SH - 1);
	localparam int VAL_MAX  = (1 << (VAL_W - 1)) - 1;
	localparam int VAL_MIN  = -(1 << (VAL_W - 1));

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_COEF_UP,
		REG_COEF_LEFT,
		REG_COEF_DIAG,
		REG_GAIN_FIRST_COLUMN,
		REG_GAIN_FIRST_ROW,
		REG_GAIN_INNER,
		REG_LINE_WIDTH
	} cfg_reg_t;

	// pixel position class from the scan tracker
	typedef struct packed {
		logic             origin;
		logic             first_row;
		logic             col0;
		logic [COL_W-1:0] col;
	} pix_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/ar2d_random_field_filter_top.sv]
// Two-dimensional first-order autoregressive random field generator. Feed one
// Q4.12 noise beat per pixel in raster order on s_*, with tuser high on the
// first pixel of a frame (the first pixel after reset is an origin anyway);
// each beat gives one Q8.12 field beat on m_*, with tuser set when the value was
// clipped. Throughput is one pixel per clock unless m_tready stalls; a pixel
// passes the stage 1 and result registers. The rate is set by the left-neighbor
// feedback: the three coefficient multipliers, the four-term sum, rounding and
// saturation of one pixel complete in a single stage so the next pixel can use the
// result at once. The previous line lives in a 1024-entry one-read, one-write line
// store that is not cleared; line_width is clamped to 2..1024; registers are to be
// written only while the stream is idle; the block itself does not enforce this.
`default_nettype none

module ar2d_random_field_filter_top import arff_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_wr_en,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wr_data,
	// noise input
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // [15:0] noise_sample
	input  wire logic                 s_tuser,   // [0] frame_start
	// field output
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,   // [19:0] field_value, zero fill above
	output logic                      m_tuser    // [0] saturated
);

	logic signed [COEF_W-1:0] coef_up_q;
	logic signed [COEF_W-1:0] coef_left_q;
	logic signed [COEF_W-1:0] coef_diag_q;
	logic [GAIN_W-1:0]        gain_first_column_q;
	logic [GAIN_W-1:0]        gain_first_row_q;
	logic [GAIN_W-1:0]        gain_inner_q;
	logic [LW_W-1:0]          line_width_q;

	logic                     en;
	logic                     accept;
	pix_ctrl_t                ctrl;
	logic [VAL_W-1:0]         up_rd;
	logic                     ram_we;
	logic [COL_W-1:0]         ram_waddr;
	logic [VAL_W-1:0]         ram_wdata;
	logic                     valid_s2;
	logic signed [VAL_W-1:0]  field_value_s2;
	logic                     saturated_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_up_q           <= '0;
			coef_left_q         <= '0;
			coef_diag_q         <= '0;
			gain_first_column_q <= '1;
			gain_first_row_q    <= '1;
			gain_inner_q        <= '1;
			line_width_q        <= LW_W'(750);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_UP:           coef_up_q           <= cfg_wr_data[COEF_W-1:0];
				REG_COEF_LEFT:         coef_left_q         <= cfg_wr_data[COEF_W-1:0];
				REG_COEF_DIAG:         coef_diag_q         <= cfg_wr_data[COEF_W-1:0];
				REG_GAIN_FIRST_COLUMN: gain_first_column_q <= cfg_wr_data[GAIN_W-1:0];
				REG_GAIN_FIRST_ROW:    gain_first_row_q    <= cfg_wr_data[GAIN_W-1:0];
				REG_GAIN_INNER:        gain_inner_q        <= cfg_wr_data[GAIN_W-1:0];
				REG_LINE_WIDTH:        line_width_q        <= cfg_wr_data[LW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// whole pipe advances whenever the result register is free or draining
	assign en       = !valid_s2 || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	arff_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (s_tuser),
		.line_width  (line_width_q),
		.ctrl        (ctrl)
	);

	// previous line, read at the accept edge, written as results form
	arff_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_LINE_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ctrl.col),
		.rdata (up_rd)
	);

	arff_mac u_mac (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.accept            (accept),
		.noise             (s_tdata[NOISE_W-1:0]),
		.ctrl              (ctrl),
		.coef_up           (coef_up_q),
		.coef_left         (coef_left_q),
		.coef_diag         (coef_diag_q),
		.gain_first_column (gain_first_column_q),
		.gain_first_row    (gain_first_row_q),
		.gain_inner        (gain_inner_q),
		.up_rd             (up_rd),
		.ram_we            (ram_we),
		.ram_waddr         (ram_waddr),
		.ram_wdata         (ram_wdata),
		.valid_s2          (valid_s2),
		.field_value_s2    (field_value_s2),
		.saturated_s2      (saturated_s2)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = M_TDATA_W'(unsigned'(field_value_s2));
	assign m_tuser  = saturated_s2;

	// an empty result register never holds off the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("top: input stalled with empty output");

endmodule

`default_nettype wire

[rtl/core/arff_ram.sv]
`default_nettype none

module arff_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/arff_scan.sv]
`default_nettype none

module arff_scan import arff_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic            frame_start,
	input  wire logic [LW_W-1:0] line_width,
	output pix_ctrl_t            ctrl
);

	logic [COL_W-1:0] col_q;
	logic             first_q;
	logic [CMP_W-1:0] lw_ext;
	logic [CMP_W-1:0] width_eff;
	logic [CMP_W-1:0] col_nxt;
	logic [COL_W-1:0] col_cur;
	logic             first_cur;

	// clamp width, restart on frame start, wrap if width shrank mid-line
	always_comb begin
		lw_ext = CMP_W'(line_width);
		if (lw_ext < CMP_W'(2)) begin
			width_eff = CMP_W'(2);
		end else if (lw_ext > CMP_W'(MAX_LINE_WIDTH)) begin
			width_eff = CMP_W'(MAX_LINE_WIDTH);
		end else begin
			width_eff = lw_ext;
		end
		col_cur   = frame_start ? '0 : col_q;
		first_cur = frame_start ? 1'b1 : first_q;
		if (CMP_W'(col_cur) >= width_eff) begin
			col_cur   = '0;
			first_cur = 1'b0;
		end
		col_nxt = CMP_W'(col_cur) + CMP_W'(1);
	end

	assign ctrl.origin    = first_cur && (col_cur == '0);
	assign ctrl.first_row = first_cur;
	assign ctrl.col0      = (col_cur == '0);
	assign ctrl.col       = col_cur;

	// position state advances once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (col_nxt >= width_eff) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q   <= col_nxt[COL_W-1:0];
				first_q <= first_cur;
			end
		end
	end

	// a frame start leaves the tracker at column 1 of the first row
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> (col_q == COL_W'(1)) && first_q)
		else $error("scan: frame start did not restart at the origin");

	// the first row is entered again only through a frame start
	a_first_row_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q && !(accept && frame_start) |=> !first_q)
		else $error("scan: first row re-entered without frame start");

endmodule

`default_nettype wire

[rtl/core/arff_mac.sv]
`default_nettype none

module arff_mac import arff_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     accept,
	input  wire logic signed [NOISE_W-1:0] noise,
	input  wire pix_ctrl_t                ctrl,
	input  wire logic signed [COEF_W-1:0] coef_up,
	input  wire logic signed [COEF_W-1:0] coef_left,
	input  wire logic signed [COEF_W-1:0] coef_diag,
	input  wire logic [GAIN_W-1:0]        gain_first_column,
	input  wire logic [GAIN_W-1:0]        gain_first_row,
	input  wire logic [GAIN_W-1:0]        gain_inner,
	input  wire logic signed [VAL_W-1:0]  up_rd,
	output logic                          ram_we,
	output logic [COL_W-1:0]              ram_waddr,
	output logic [VAL_W-1:0]              ram_wdata,
	output logic                          valid_s2,
	output logic signed [VAL_W-1:0]       field_value_s2,
	output logic                          saturated_s2
);

	// stage 1: noise term and term selects
	logic [GAIN_W-1:0]        gain_sel;
	logic signed [GAIN_W:0]   gain_s;
	logic signed [PN_W-1:0]   pn_c;
	logic                     valid_s1;
	logic signed [PN_W-1:0]   pn_s1;
	logic                     use_up_s1;
	logic                     use_left_s1;
	logic                     use_diag_s1;
	logic                     origin_s1;
	logic [COL_W-1:0]         col_s1;

	// stage 2: neighbor terms, rounding, saturation
	logic signed [VAL_W-1:0]  left_q;
	logic signed [VAL_W-1:0]  diag_q;
	logic signed [PROD_W-1:0] prod_up;
	logic signed [PROD_W-1:0] prod_left;
	logic signed [PROD_W-1:0] prod_diag;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [VAL_W-1:0]  val_c;
	logic                     sat_c;

	// noise gain per pixel class; the origin passes noise through at Q.27
	always_comb begin
		if (ctrl.first_row) begin
			gain_sel = gain_first_row;
		end else if (ctrl.col0) begin
			gain_sel = gain_first_column;
		end else begin
			gain_sel = gain_inner;
		end
		gain_s = signed'({1'b0, gain_sel});
		if (ctrl.origin) begin
			pn_c = PN_W'(noise) <<< RND_SH;
		end else begin
			pn_c = gain_s * noise;
		end
	end

	always_ff @(posedge clk) begin
		if (en && accept) begin
			pn_s1       <= pn_c;
			use_up_s1   <= !ctrl.first_row;
			use_left_s1 <= !ctrl.col0;
			use_diag_s1 <= !ctrl.first_row && !ctrl.col0;
			origin_s1   <= ctrl.origin;
			col_s1      <= ctrl.col;
		end
	end

	// sum the neighbor terms at Q.27, round half up to Q.12, clip to 20 bits
	always_comb begin
		prod_up   = coef_up * up_rd;
		prod_left = coef_left * left_q;
		prod_diag = coef_diag * diag_q;
		acc = ACC_W'(pn_s1) + ACC_W'(RND_HALF);
		if (use_up_s1) begin
			acc = acc + ACC_W'(prod_up);
		end
		if (use_left_s1) begin
			acc = acc + ACC_W'(prod_left);
		end
		if (use_diag_s1) begin
			acc = acc - ACC_W'(prod_diag);
		end
		rnd = acc >>> RND_SH;
		if (rnd > ACC_W'(VAL_MAX)) begin
			val_c = VAL_W'(VAL_MAX);
			sat_c = 1'b1;
		end else if (rnd < ACC_W'(VAL_MIN)) begin
			val_c = VAL_W'(VAL_MIN);
			sat_c = 1'b1;
		end else begin
			val_c = rnd[VAL_W-1:0];
			sat_c = 1'b0;
		end
	end

	// result goes back into the line store as the next line's upper pixel
	assign ram_we    = en && valid_s1;
	assign ram_waddr = col_s1;
	assign ram_wdata = val_c;

	// control and neighbor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			left_q   <= '0;
			diag_q   <= '0;
		end else if (en) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				left_q <= val_c;
				diag_q <= up_rd;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			field_value_s2 <= val_c;
			saturated_s2   <= sat_c;
		end
	end

	// the origin copies the noise and cannot clip
	a_origin_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && origin_s1 |=> !saturated_s2)
		else $error("mac: origin pixel flagged as saturated");

	// a beat in stage 1 reaches the result register on the next advance
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 |=> valid_s2)
		else $error("mac: stage 1 beat lost");

	// a stalled result register keeps its beat
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en |=> valid_s2 && $stable(field_value_s2))
		else $error("mac: result changed during stall");

endmodule

`default_nettype wire
